// File: hdl/dhcp_client_lease_engine_defines.svh
// ---------------------------------------------------------------------------
// dhcp_client_lease_engine_defines: assertion macros
// Immediate-implication and next-cycle-implication checks on clk / arst_n.
// ---------------------------------------------------------------------------
`ifndef DHCP_CLIENT_LEASE_ENGINE_DEFINES_SVH
`define DHCP_CLIENT_LEASE_ENGINE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DCLE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define DCLE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define DCLE_ASSERT_IMP(lbl, ante, cons)
`define DCLE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: hdl/dcle_pkg.sv
// ---------------------------------------------------------------------------
// dcle_pkg: shared types and constants of the DHCP client lease engine
// Item structs, engine state, configuration set and deadline helpers.
// ---------------------------------------------------------------------------
package dcle_pkg;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_REPLY = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;
	localparam logic [1:0] KIND_STOP  = 2'd3;

	localparam logic [1:0] RT_OFFER = 2'd0;
	localparam logic [1:0] RT_ACK   = 2'd1;
	localparam logic [1:0] RT_NAK   = 2'd2;
	localparam logic [1:0] RT_OTHER = 2'd3;

	localparam logic [2:0] PH_IDLE       = 3'd0;
	localparam logic [2:0] PH_SELECTING  = 3'd1;
	localparam logic [2:0] PH_REQUESTING = 3'd2;
	localparam logic [2:0] PH_BOUND      = 3'd3;
	localparam logic [2:0] PH_RENEWING   = 3'd4;
	localparam logic [2:0] PH_REBINDING  = 3'd5;

	localparam logic [2:0] CFG_RNG_SEED     = 3'd0;
	localparam logic [2:0] CFG_PREFERRED    = 3'd1;
	localparam logic [2:0] CFG_FIRST_RETRY  = 3'd2;
	localparam logic [2:0] CFG_MAX_RETRY    = 3'd3;
	localparam logic [2:0] CFG_MIN_RENEW    = 3'd4;
	localparam logic [2:0] CFG_MAX_ATTEMPTS = 3'd5;

	localparam logic [0:0] MSG_DISCOVER = 1'b0;
	localparam logic [0:0] MSG_REQUEST  = 1'b1;

	localparam logic [31:0] LCG_A     = 32'd1664525;
	localparam logic [31:0] LCG_C     = 32'd1013904223;
	localparam logic [63:0] LCG_A2_64 = 64'd1664525 * 64'd1664525;
	localparam logic [63:0] LCG_C2_64 = 64'd1013904223 * 64'd1664526;
	localparam logic [31:0] LCG_A2    = LCG_A2_64[31:0];
	localparam logic [31:0] LCG_C2    = LCG_C2_64[31:0];

	localparam logic [31:0] BCAST_ADDR    = 32'hFFFF_FFFF;
	localparam logic [31:0] INFINITE_SECS = 32'hFFFF_FFFF;
	localparam logic [7:0]  ATTEMPT_MAX   = 8'd255;
	localparam logic [15:0] ELAPSED_MAX   = 16'd65535;
	// 65536 seconds in ms: at or beyond this the elapsed field saturates
	localparam logic [63:0] ELAPSED_SAT_MS = 64'd65536000;
	// ceil(2^36 / 1000): exact quotient for dividends below 2^26
	localparam logic [26:0] RECIP_1000 = 27'd68719477;
	localparam int          RECIP_SHIFT = 36;

	localparam logic [31:0] RST_SEED        = 32'd1;
	localparam logic [31:0] RST_PREFERRED   = 32'd0;
	localparam logic [31:0] RST_FIRST_RETRY = 32'd4000;
	localparam logic [31:0] RST_MAX_RETRY   = 32'd64000;
	localparam logic [31:0] RST_MIN_RENEW   = 32'd60000;
	localparam logic [7:0]  RST_ATTEMPTS    = 8'd4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] now_ms;
		logic [1:0]  reply_type;
		logic [31:0] reply_xid;
		logic [31:0] lease_address;
		logic [31:0] lease_mask;
		logic [31:0] lease_router;
		logic [31:0] lease_dns;
		logic [31:0] lease_server;
		logic [31:0] lease_seconds;
		logic [31:0] renew_seconds;
		logic [31:0] rebind_seconds;
	} in_item_t;

	typedef struct packed {
		logic        send;
		logic        message_type;
		logic [31:0] transaction_id;
		logic [31:0] destination;
		logic [31:0] requested_address;
		logic [31:0] server_address;
		logic [31:0] client_address;
		logic        broadcast_flag;
		logic [15:0] elapsed_seconds;
		logic [2:0]  client_state;
		logic        lease_acquired;
		logic        lease_lost;
	} out_item_t;

	typedef struct packed {
		logic [31:0] rng_seed;
		logic [31:0] preferred_address;
		logic [31:0] first_retry_ms;
		logic [31:0] max_retry_ms;
		logic [31:0] min_renew_ms;
		logic [7:0]  max_request_attempts;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [31:0] current_xid;
		logic [31:0] generator;
		logic [31:0] held_address;
		logic [31:0] held_mask;
		logic [31:0] held_router;
		logic [31:0] held_dns;
		logic [31:0] held_server;
		logic [31:0] offer_address;
		logic [31:0] offer_server;
		logic [31:0] chosen_address;
		logic        infinite_lease;
		logic [63:0] start_time;
		logic [63:0] next_send_time;
		logic [31:0] retry_interval;
		logic [7:0]  attempt_count;
		logic [63:0] renew_time;
		logic [63:0] rebind_time;
		logic [63:0] expire_time;
		logic [63:0] last_tick_time;
	} state_t;

	function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
	endfunction

	function automatic logic [63:0] sat_sub64(input logic [63:0] a, input logic [63:0] b);
		return (a > b) ? (a - b) : 64'd0;
	endfunction

	// seconds to ms by shift and add: x*1000 = x*1024 - x*16 - x*8
	function automatic logic [63:0] secs_to_ms(input logic [31:0] x);
		logic [63:0] w;
		w = {32'd0, x};
		return (w << 10) - (w << 4) - (w << 3);
	endfunction

endpackage

// File: hdl/dcle_lcg.sv
// ---------------------------------------------------------------------------
// dcle_lcg: transaction id generator
// One and two steps of the linear congruential generator from a base value.
// ---------------------------------------------------------------------------
module dcle_lcg import dcle_pkg::*; (
	input  logic [31:0] base,
	output logic [31:0] gen1,
	output logic [31:0] gen2,
	output logic [31:0] xid1,
	output logic [31:0] xid2
);

	logic [63:0] prod1;
	logic [63:0] prod2;

	// two steps fold into one multiply by a^2 plus c*(a+1)
	assign prod1 = {32'd0, base} * {32'd0, LCG_A};
	assign prod2 = {32'd0, base} * {32'd0, LCG_A2};
	assign gen1  = prod1[31:0] + LCG_C;
	assign gen2  = prod2[31:0] + LCG_C2;
	assign xid1  = (gen1 == 32'd0) ? 32'd1 : gen1;
	assign xid2  = (gen2 == 32'd0) ? 32'd1 : gen2;

endmodule

// File: hdl/dcle_elapsed.sv
// ---------------------------------------------------------------------------
// dcle_elapsed: elapsed seconds of a transaction
// Clamped difference in ms, divided by 1000 by reciprocal, saturated.
// ---------------------------------------------------------------------------
module dcle_elapsed import dcle_pkg::*; (
	input  logic [63:0] now_ms,
	input  logic [63:0] start_ms,
	output logic [15:0] elapsed
);

	logic [63:0] diff;
	logic [52:0] prod;

	assign diff = sat_sub64(now_ms, start_ms);
	assign prod = {27'd0, diff[25:0]} * {26'd0, RECIP_1000};

	always_comb begin
		if (diff >= ELAPSED_SAT_MS) begin
			elapsed = ELAPSED_MAX;
		end else begin
			elapsed = prod[RECIP_SHIFT +: 16];
		end
	end

endmodule

// File: hdl/dcle_step.sv
// ---------------------------------------------------------------------------
// dcle_step: next-state and result logic for one beat
// Decodes start, stop, reply and tick beats against the held engine state.
// ---------------------------------------------------------------------------
module dcle_step import dcle_pkg::*; (
	input  state_t    st,
	input  cfg_t      cfg,
	input  in_item_t  item,
	output state_t    st_next,
	output out_item_t res
);

	logic [31:0] lcg_base;
	logic [31:0] gen1;
	logic [31:0] gen2;
	logic [31:0] xid1;
	logic [31:0] xid2;
	logic [15:0] elapsed;
	out_item_t   r;

	function automatic state_t begin_txn(input state_t s0, input logic [2:0] ph,
			input logic [63:0] now, input logic [31:0] xid, input logic [31:0] first);
		state_t s1;
		s1 = s0;
		s1.phase          = ph;
		s1.current_xid    = xid;
		s1.start_time     = now;
		s1.next_send_time = now;
		s1.retry_interval = first;
		s1.attempt_count  = 8'd0;
		return s1;
	endfunction

	function automatic state_t drop_lease(input state_t s0);
		state_t s1;
		s1 = s0;
		s1.held_address   = '0;
		s1.held_mask      = '0;
		s1.held_router    = '0;
		s1.held_dns       = '0;
		s1.held_server    = '0;
		s1.infinite_lease = 1'b0;
		s1.renew_time     = '0;
		s1.rebind_time    = '0;
		s1.expire_time    = '0;
		return s1;
	endfunction

	assign lcg_base = (item.kind == KIND_START) ?
		((cfg.rng_seed == 32'd0) ? 32'd1 : cfg.rng_seed) : st.generator;

	dcle_lcg u_lcg (
		.base (lcg_base),
		.gen1 (gen1),
		.gen2 (gen2),
		.xid1 (xid1),
		.xid2 (xid2)
	);

	always_comb begin
		state_t      s;
		logic [1:0]  nd;
		logic        go;
		logic        acq;
		logic        lost;
		logic [63:0] now;
		logic [63:0] step;
		logic [31:0] mask;
		logic [31:0] rtr;
		logic [31:0] dns;
		logic [31:0] srv;
		logic [63:0] lease_ms;
		logic [63:0] renew_ms;
		logic [63:0] rebind_ms;
		logic [63:0] min_ms;
		logic [32:0] dbl;

		s    = st;
		r    = '0;
		nd   = 2'd0;
		go   = 1'b1;
		acq  = 1'b0;
		lost = 1'b0;
		now  = item.now_ms;
		step = st.last_tick_time - now;
		mask = item.lease_mask;
		rtr  = item.lease_router;
		dns  = item.lease_dns;
		srv  = item.lease_server;
		lease_ms  = secs_to_ms(item.lease_seconds);
		renew_ms  = secs_to_ms(item.renew_seconds);
		rebind_ms = secs_to_ms(item.rebind_seconds);
		min_ms    = {32'd0, cfg.min_renew_ms};
		dbl       = '0;

		unique case (item.kind)
			KIND_START: begin
				s = drop_lease(s);
				s.offer_address  = '0;
				s.offer_server   = '0;
				s.last_tick_time = now;
				s = begin_txn(s, PH_SELECTING, now, xid1, cfg.first_retry_ms);
				nd = 2'd1;
			end
			KIND_STOP: begin
				s.phase         = PH_IDLE;
				s.offer_address = '0;
				s.offer_server  = '0;
			end
			KIND_REPLY: begin
				if (st.phase != PH_IDLE && item.reply_type != RT_OTHER &&
						item.reply_xid == st.current_xid) begin
					if (st.phase == PH_SELECTING) begin
						if (item.reply_type == RT_OFFER && item.lease_address != 32'd0) begin
							s.offer_address  = item.lease_address;
							s.offer_server   = item.lease_server;
							s.phase          = PH_REQUESTING;
							s.attempt_count  = 8'd0;
							s.retry_interval = cfg.first_retry_ms;
							s.next_send_time = now;
						end
					end else if (st.phase == PH_REQUESTING || st.phase == PH_RENEWING ||
							st.phase == PH_REBINDING) begin
						if (item.reply_type == RT_ACK) begin
							if (item.lease_address != 32'd0 && item.lease_seconds != 32'd0) begin
								if (mask == 32'd0) mask = st.held_mask;
								if (rtr == 32'd0) rtr = st.held_router;
								if (dns == 32'd0) dns = st.held_dns;
								if (srv == 32'd0) begin
									srv = (st.held_server != 32'd0) ? st.held_server :
										st.offer_server;
								end
								acq = item.lease_address != st.held_address ||
									mask != st.held_mask || rtr != st.held_router ||
									dns != st.held_dns;
								s.held_address   = item.lease_address;
								s.held_mask      = mask;
								s.held_router    = rtr;
								s.held_dns       = dns;
								s.held_server    = srv;
								s.chosen_address = item.lease_address;
								s.offer_address  = '0;
								s.offer_server   = '0;
								s.phase          = PH_BOUND;
								s.attempt_count  = 8'd0;
								s.retry_interval = cfg.first_retry_ms;
								s.infinite_lease = item.lease_seconds == INFINITE_SECS;
								if (s.infinite_lease) begin
									s.renew_time  = '0;
									s.rebind_time = '0;
									s.expire_time = '0;
								end else begin
									if (renew_ms < min_ms) begin
										renew_ms = (min_ms < (lease_ms >> 1)) ? min_ms :
											(lease_ms >> 1);
									end
									if (rebind_ms <= renew_ms || rebind_ms >= lease_ms) begin
										rebind_ms = renew_ms + ((lease_ms > renew_ms) ?
											((lease_ms - renew_ms) >> 1) : 64'd0);
									end
									s.renew_time  = sat_add64(now, renew_ms);
									s.rebind_time = sat_add64(now, rebind_ms);
									s.expire_time = sat_add64(now, lease_ms);
								end
							end
						end else if (item.reply_type == RT_NAK) begin
							lost = st.held_address != 32'd0;
							s = drop_lease(s);
							s.offer_address = '0;
							s.offer_server  = '0;
							s = begin_txn(s, PH_SELECTING, now, xid1, cfg.first_retry_ms);
							nd = 2'd1;
						end
					end
				end
			end
			default: begin
				if (st.phase != PH_IDLE) begin
					// clock stepped back: pull every deadline back by the same amount
					if (now < st.last_tick_time) begin
						s.start_time     = sat_sub64(s.start_time, step);
						s.next_send_time = sat_sub64(s.next_send_time, step);
						s.renew_time     = sat_sub64(s.renew_time, step);
						s.rebind_time    = sat_sub64(s.rebind_time, step);
						s.expire_time    = sat_sub64(s.expire_time, step);
					end
					s.last_tick_time = now;
					if (s.phase == PH_BOUND) begin
						if (s.infinite_lease || now < s.renew_time) begin
							go = 1'b0;
						end else begin
							s = begin_txn(s, PH_RENEWING, now, xid1, cfg.first_retry_ms);
							nd = 2'd1;
						end
					end else if (s.phase == PH_RENEWING && now >= s.rebind_time) begin
						s = begin_txn(s, PH_REBINDING, now, xid1, cfg.first_retry_ms);
						nd = 2'd1;
					end
					if (go) begin
						if ((s.phase == PH_RENEWING || s.phase == PH_REBINDING) &&
								now >= s.expire_time) begin
							s = drop_lease(s);
							lost = 1'b1;
							s.offer_address = '0;
							s.offer_server  = '0;
							s = begin_txn(s, PH_SELECTING, now, (nd == 2'd0) ? xid1 : xid2,
								cfg.first_retry_ms);
							nd = nd + 2'd1;
						end
						if (s.phase == PH_REQUESTING &&
								s.attempt_count >= cfg.max_request_attempts) begin
							s.offer_address = '0;
							s.offer_server  = '0;
							s = begin_txn(s, PH_SELECTING, now, (nd == 2'd0) ? xid1 : xid2,
								cfg.first_retry_ms);
							nd = nd + 2'd1;
						end
						if (now >= s.next_send_time) begin
							if (s.phase == PH_RENEWING && s.held_server == 32'd0) begin
								s = begin_txn(s, PH_REBINDING, now, (nd == 2'd0) ? xid1 : xid2,
									cfg.first_retry_ms);
								nd = nd + 2'd1;
							end
							r.send           = 1'b1;
							r.message_type   = (s.phase == PH_SELECTING) ? MSG_DISCOVER :
								MSG_REQUEST;
							r.transaction_id = s.current_xid;
							if (s.phase == PH_SELECTING) begin
								r.destination       = BCAST_ADDR;
								r.requested_address = s.chosen_address;
								r.broadcast_flag    = 1'b1;
							end else if (s.phase == PH_REQUESTING) begin
								r.destination       = BCAST_ADDR;
								r.requested_address = s.offer_address;
								r.server_address    = s.offer_server;
								r.broadcast_flag    = 1'b1;
							end else if (s.phase == PH_RENEWING) begin
								r.destination    = s.held_server;
								r.client_address = s.held_address;
							end else begin
								r.destination    = BCAST_ADDR;
								r.client_address = s.held_address;
								r.broadcast_flag = 1'b1;
							end
							// back off: count the attempt and double the interval to the cap
							if (s.attempt_count < ATTEMPT_MAX) begin
								s.attempt_count = s.attempt_count + 8'd1;
							end
							s.next_send_time = sat_add64(now, {32'd0, s.retry_interval});
							dbl = {s.retry_interval, 1'b0};
							if (dbl > {1'b0, cfg.max_retry_ms}) dbl = {1'b0, cfg.max_retry_ms};
							s.retry_interval = dbl[31:0];
						end
					end
				end
			end
		endcase

		unique case (nd)
			2'd0:    s.generator = st.generator;
			2'd1:    s.generator = gen1;
			default: s.generator = gen2;
		endcase

		r.client_state   = s.phase;
		r.lease_acquired = acq;
		r.lease_lost     = lost;
		st_next = s;
	end

	dcle_elapsed u_elapsed (
		.now_ms   (item.now_ms),
		.start_ms (st_next.start_time),
		.elapsed  (elapsed)
	);

	always_comb begin
		res = r;
		res.elapsed_seconds = r.send ? elapsed : 16'd0;
	end

endmodule

// File: hdl/dhcp_client_lease_engine.sv
// Datapath: a beat is taken into the input register, and its result is then
// registered at the output once the result register is free or unstalled.
// Throughput: one beat per cycle, set by the single-pass step logic, unless out_stall holds the output.
// Reset (arst_n low) returns the engine to idle, loads register defaults and
// empties both registers; no clearing pass is needed.
// ---------------------------------------------------------------------------
// dhcp_client_lease_engine: DHCP client lease engine, top level
// Input register, step logic, engine state, configuration and result register.
// ---------------------------------------------------------------------------
`include "dhcp_client_lease_engine_defines.svh"

module dhcp_client_lease_engine import dcle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam state_t ST_RESET = '{
		phase:          PH_IDLE,
		generator:      32'd1,
		chosen_address: RST_PREFERRED,
		retry_interval: RST_FIRST_RETRY,
		default:        '0
	};

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_s2;
	logic      valid_s2;
	state_t    state_q;
	state_t    state_d;
	cfg_t      cfg_q;
	out_item_t res;
	logic      advance;
	logic      take;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	dcle_step u_step (
		.st      (state_q),
		.cfg     (cfg_q),
		.item    (item_s1),
		.st_next (state_d),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RESET;
		end else if (advance) begin
			state_q <= state_d;
		end else if (cfg_we && cfg_index == CFG_PREFERRED) begin
			// a new preferred address is also the next one asked for
			state_q.chosen_address <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rng_seed             <= RST_SEED;
			cfg_q.preferred_address    <= RST_PREFERRED;
			cfg_q.first_retry_ms       <= RST_FIRST_RETRY;
			cfg_q.max_retry_ms         <= RST_MAX_RETRY;
			cfg_q.min_renew_ms         <= RST_MIN_RENEW;
			cfg_q.max_request_attempts <= RST_ATTEMPTS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RNG_SEED:     cfg_q.rng_seed             <= cfg_data;
				CFG_PREFERRED:    cfg_q.preferred_address    <= cfg_data;
				CFG_FIRST_RETRY:  cfg_q.first_retry_ms       <= cfg_data;
				CFG_MAX_RETRY:    cfg_q.max_retry_ms         <= cfg_data;
				CFG_MIN_RENEW:    cfg_q.min_renew_ms         <= cfg_data;
				CFG_MAX_ATTEMPTS: cfg_q.max_request_attempts <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	`DCLE_ASSERT_IMP(a_quiet_no_send, valid_s2 && !res_s2.send, res_s2.transaction_id == 32'd0 && res_s2.destination == 32'd0 && res_s2.elapsed_seconds == 16'd0)
	`DCLE_ASSERT_IMP(a_idle_silent, valid_s2 && res_s2.client_state == PH_IDLE, !res_s2.send)
	`DCLE_ASSERT_IMP(a_acquire_bound, valid_s2 && res_s2.lease_acquired, res_s2.client_state == PH_BOUND)
	`DCLE_ASSERT_NXT(a_state_follows, advance, out_valid && out_data.client_state == state_q.phase)

endmodule
